// ===== sv/cpcs_pkg.sv =====
// ----------------------------------------------------------------------------
// cpcs_pkg: shared types and constants of the column profile segmenter
// word layouts for both channels, the event passed from front to back,
// register indexes and reset values
// ----------------------------------------------------------------------------
package cpcs_pkg;

   localparam int PIX_W   = 8;
   localparam int SUM_W   = 16;
   localparam int COL_W   = 12;
   localparam int LIM_W   = 12;
   localparam int ADDR_W  = 3;
   localparam int DATA_W  = 32;

   // column counter wraps to zero after this many columns
   localparam int MAX_COLUMNS = 4096;

   // default depth of the event queue between front and back
   localparam int QUEUE_DEPTH = 4;

   localparam logic [SUM_W-1:0] LIGHT_THRESHOLD_RESET = 16'd37000;
   localparam logic [LIM_W-1:0] SPACE_LIMIT_RESET     = 12'd25;

   typedef enum logic {
      REG_LIGHT_THRESHOLD = 1'b0,
      REG_SPACE_LIMIT     = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      KIND_CHAR  = 2'd0,
      KIND_SPACE = 2'd1,
      KIND_EOL   = 2'd2
   } seg_kind_type;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic             column_end;
      logic             line_end;
   } req_word_type;

   typedef struct packed {
      seg_kind_type     seg_kind;
      logic [COL_W-1:0] seg_start;
      logic [COL_W-1:0] seg_width;
      logic             last_of_run;
   } rsp_word_type;

   typedef struct packed {
      logic [SUM_W-1:0] light_threshold;
      logic [LIM_W-1:0] space_limit;
   } cfg_type;

   // one classified column event, expanded into results by the back end
   typedef struct packed {
      logic             char_seen;   // a run closed on this column
      logic             eol_seen;    // line ended on this pixel
      logic             space_ok;    // previous character end is valid
      logic [COL_W-1:0] run_start;
      logic [COL_W-1:0] prev_end;
      logic [COL_W-1:0] close_col;
   } seg_event_type;

endpackage

// ===== sv/cpcs_csr.sv =====
// ----------------------------------------------------------------------------
// cpcs_csr: configuration registers
// apb-style register file holding the light threshold and space limit
// ----------------------------------------------------------------------------
module cpcs_csr
   import cpcs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   logic [SUM_W-1:0] light_threshold_ff, light_threshold_in;
   logic [LIM_W-1:0] space_limit_ff, space_limit_in;
   logic             wr_en;
   reg_index_type    reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = reg_index_type'(paddr[2]);

   always_comb begin
      light_threshold_in = light_threshold_ff;
      space_limit_in     = space_limit_ff;
      prdata             = '0;
      case (reg_sel)
         REG_LIGHT_THRESHOLD: begin
            if (wr_en) light_threshold_in = pwdata[SUM_W-1:0];
            prdata = {{(DATA_W-SUM_W){1'b0}}, light_threshold_ff};
         end
         REG_SPACE_LIMIT: begin
            if (wr_en) space_limit_in = pwdata[LIM_W-1:0];
            prdata = {{(DATA_W-LIM_W){1'b0}}, space_limit_ff};
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         light_threshold_ff <= LIGHT_THRESHOLD_RESET;
         space_limit_ff     <= SPACE_LIMIT_RESET;
      end else begin
         light_threshold_ff <= light_threshold_in;
         space_limit_ff     <= space_limit_in;
      end
   end

   assign cfg.light_threshold = light_threshold_ff;
   assign cfg.space_limit     = space_limit_ff;

endmodule

// ===== sv/cpcs_front.sv =====
// ----------------------------------------------------------------------------
// cpcs_front: column accumulator and classifier
// sums r+g+b down each column, tracks ink runs and raises column events
// ----------------------------------------------------------------------------
module cpcs_front
   import cpcs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          accept,
   input  req_word_type  word,
   output logic          ev_valid,
   output seg_event_type ev
);

   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic             run_open_ff, run_open_in;
   logic [COL_W-1:0] run_start_ff, run_start_in;
   logic             prev_valid_ff, prev_valid_in;
   logic [COL_W-1:0] prev_end_ff, prev_end_in;

   logic [SUM_W+1:0] sum_wide;
   logic [SUM_W-1:0] sum_sat;
   logic [COL_W:0]   col_inc;
   logic [COL_W-1:0] col_next;
   logic             col_done;
   logic             blank;
   logic             char_close;

   always_comb begin
      sum_wide = {2'b00, sum_ff} + {{(SUM_W+2-PIX_W){1'b0}}, word.red}
               + {{(SUM_W+2-PIX_W){1'b0}}, word.green}
               + {{(SUM_W+2-PIX_W){1'b0}}, word.blue};
      // saturate at all ones
      sum_sat  = (sum_wide[SUM_W+1:SUM_W] != 2'b00) ? '1 : sum_wide[SUM_W-1:0];
      col_inc  = {1'b0, col_ff} + {{COL_W{1'b0}}, 1'b1};
      col_next = (32'(col_inc) >= MAX_COLUMNS) ? '0 : col_inc[COL_W-1:0];
      col_done = word.column_end | word.line_end;
      blank    = sum_sat > cfg.light_threshold;
      char_close = col_done & blank & run_open_ff;

      sum_in        = sum_ff;
      col_in        = col_ff;
      run_open_in   = run_open_ff;
      run_start_in  = run_start_ff;
      prev_valid_in = prev_valid_ff;
      prev_end_in   = prev_end_ff;

      if (accept) begin
         sum_in = sum_sat;
         if (col_done) begin
            if (blank) begin
               if (run_open_ff) begin
                  prev_end_in   = col_ff;
                  prev_valid_in = 1'b1;
                  run_open_in   = 1'b0;
               end
            end else if (!run_open_ff) begin
               // run opens one column early, clamped at the left edge
               run_start_in = (col_ff == '0) ? '0 : col_ff - {{(COL_W-1){1'b0}}, 1'b1};
               run_open_in  = 1'b1;
            end
            sum_in = '0;
            col_in = col_next;
         end
         if (word.line_end) begin
            col_in        = '0;
            run_open_in   = 1'b0;
            run_start_in  = '0;
            prev_valid_in = 1'b0;
            prev_end_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff        <= '0;
         col_ff        <= '0;
         run_open_ff   <= 1'b0;
         run_start_ff  <= '0;
         prev_valid_ff <= 1'b0;
         prev_end_ff   <= '0;
      end else begin
         sum_ff        <= sum_in;
         col_ff        <= col_in;
         run_open_ff   <= run_open_in;
         run_start_ff  <= run_start_in;
         prev_valid_ff <= prev_valid_in;
         prev_end_ff   <= prev_end_in;
      end
   end

   assign ev_valid     = accept & (char_close | word.line_end);
   assign ev.char_seen = char_close;
   assign ev.eol_seen  = word.line_end;
   assign ev.space_ok  = prev_valid_ff;
   assign ev.run_start = run_start_ff;
   assign ev.prev_end  = prev_end_ff;
   assign ev.close_col = col_ff;

endmodule

// ===== sv/cpcs_evq.sv =====
// ----------------------------------------------------------------------------
// cpcs_evq: event queue
// small fifo of column events between the classifier and the result stage
// ----------------------------------------------------------------------------
module cpcs_evq
   import cpcs_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          enq,
   input  seg_event_type enq_ev,
   input  logic          deq,
   output seg_event_type head,
   output logic          head_valid,
   output logic          full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   seg_event_type    mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_deq;

   assign full       = count_ff == CNT_W'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head       = mem_ff[rd_ptr_ff];
   assign do_deq     = deq & head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (enq) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_deq) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({enq, do_deq})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) mem_ff[wr_ptr_ff] <= enq_ev;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("event queue count beyond depth");

   a_enq_has_room: assert property (@(posedge clock) disable iff (reset)
      enq |-> !full)
      else $error("event pushed into full queue");

endmodule

// ===== sv/cpcs_back.sv =====
// ----------------------------------------------------------------------------
// cpcs_back: result sequencer
// expands each column event into space, character and end of line words
// ----------------------------------------------------------------------------
module cpcs_back
   import cpcs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  seg_event_type head,
   input  logic          head_valid,
   output logic          deq,
   input  logic          pop,
   output logic          empty,
   output rsp_word_type  word
);

   logic             out_valid_ff, out_valid_in;
   rsp_word_type     out_ff;
   logic             sp_done_ff, sp_done_in;
   logic             ch_done_ff, ch_done_in;

   logic [COL_W-1:0] gap;
   logic [COL_W-1:0] glyph_width;
   logic             has_space;
   logic             load;
   seg_kind_type     cur_kind;
   logic             cur_last;
   rsp_word_type     cur_word;

   always_comb begin
      gap         = head.run_start - head.prev_end;
      glyph_width = head.close_col - {{(COL_W-1){1'b0}}, 1'b1} - head.run_start;
      has_space   = head.char_seen & head.space_ok & (gap > cfg.space_limit);

      if (has_space && !sp_done_ff) begin
         cur_kind = KIND_SPACE;
         cur_last = 1'b0;
      end else if (head.char_seen && !ch_done_ff) begin
         cur_kind = KIND_CHAR;
         cur_last = !head.eol_seen;
      end else begin
         cur_kind = KIND_EOL;
         cur_last = 1'b1;
      end

      cur_word.seg_kind    = cur_kind;
      cur_word.last_of_run = cur_last;
      case (cur_kind)
         KIND_SPACE: begin
            cur_word.seg_start = head.prev_end;
            cur_word.seg_width = gap;
         end
         KIND_CHAR: begin
            cur_word.seg_start = head.run_start;
            cur_word.seg_width = glyph_width;
         end
         default: begin
            cur_word.seg_start = '0;
            cur_word.seg_width = '0;
         end
      endcase

      load         = head_valid & (!out_valid_ff | pop);
      deq          = load & cur_last;
      out_valid_in = load | (out_valid_ff & !pop);

      sp_done_in = sp_done_ff;
      ch_done_in = ch_done_ff;
      if (load) begin
         if (cur_last) begin
            sp_done_in = 1'b0;
            ch_done_in = 1'b0;
         end else if (cur_kind == KIND_SPACE) begin
            sp_done_in = 1'b1;
         end else begin
            ch_done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         sp_done_ff   <= 1'b0;
         ch_done_ff   <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         sp_done_ff   <= sp_done_in;
         ch_done_ff   <= ch_done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) out_ff <= cur_word;
   end

   assign empty = !out_valid_ff;
   assign word  = out_ff;

   a_progress_needs_head: assert property (@(posedge clock) disable iff (reset)
      (sp_done_ff || ch_done_ff) |-> head_valid)
      else $error("partial expansion without an event at the head");

   a_load_fills: assert property (@(posedge clock) disable iff (reset)
      load |=> out_valid_ff)
      else $error("output register empty after load");

endmodule

// ===== sv/column_profile_char_segmenter.sv =====
// ----------------------------------------------------------------------------
// column_profile_char_segmenter: character segmentation by column profile
// splits one text-line band into character, space and end of line segments
// ----------------------------------------------------------------------------
// Pixels of a text-line band enter in column-major order, one word per
// cycle; the block takes one pixel per clock while full is low. The front
// end adds r+g+b down each column (saturating at 16 bits) and, on the last
// pixel of a column, calls the column blank when its sum exceeds
// light_threshold. Ink runs open at the column before the first ink column
// and close at the next blank column, which yields a character word; a gap
// wider than space_limit since the previous character of the same line is
// reported first as a space word. line_end forces the end of the column,
// emits an end of line word, drops any open run and forgets the previous
// character. A pixel yields zero to three result words; results leave one
// per clock while pop keeps the registered output stage free, so the event
// queue (depth QUEUE_DEPTH) soaks up the bursts while the pixel side keeps
// moving. full is raised only when that queue is full. A pixel's event is
// queued, then expanded into the output register. Registers:
// light_threshold at 0x0, space_limit at 0x4, both readable.
// ----------------------------------------------------------------------------
module column_profile_char_segmenter
   import cpcs_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
   input  logic              clock,
   input  logic              reset,
   // pixel side
   input  logic              push,
   output logic              full,
   input  req_word_type      req_data,
   // result side
   output logic              empty,
   input  logic              pop,
   output rsp_word_type      rsp_data,
   // register port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   cfg_type       cfg;
   logic          accept;
   logic          ev_valid;
   seg_event_type ev;
   seg_event_type head;
   logic          head_valid;
   logic          deq;

   // a pixel word is taken whenever the queue has room
   assign accept = push & !full;

   cpcs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // column sums, run tracking and event generation
   cpcs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .accept   (accept),
      .word     (req_data),
      .ev_valid (ev_valid),
      .ev       (ev)
   );

   // decouples the pixel side from result bursts
   cpcs_evq #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_evq (
      .clock      (clock),
      .reset      (reset),
      .enq        (ev_valid),
      .enq_ev     (ev),
      .deq        (deq),
      .head       (head),
      .head_valid (head_valid),
      .full       (full)
   );

   // one result word per clock into the output register while it is empty or popped
   cpcs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head       (head),
      .head_valid (head_valid),
      .deq        (deq),
      .pop        (pop),
      .empty      (empty),
      .word       (rsp_data)
   );

endmodule
